@@ hdl/sha_pkg.sv @@
`default_nettype none

package sha_pkg;

  localparam int unsigned CHAIN_WORDS = 8;
  localparam int unsigned ROUNDS      = 64;

  localparam logic [7:0] PAD_MARKER = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_of_message;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic [31:0] folded_digest;
    logic        last_word;
  } out_t;

  localparam logic [31:0] INIT_H [CHAIN_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

@@ hdl/sha_ram.sv @@
`default_nettype none

module sha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/sha256_message_hasher_unit.sv @@
`default_nettype none

// SHA-256 hasher over a byte stream.
// Input channel: one request per byte (in_data_i.has_byte), with last_of_message
// closing the message; a request with neither flag is taken and dropped. A byte
// request is taken while the unit is idle. When the 64th byte of a block lands,
// the input stalls while the block is compressed: the chaining words are fetched
// from their RAM, the 64 rounds run (one round a cycle, fed by the 16-word block
// RAM and a 16-word rolling schedule), then the chaining words are read, added
// and written back. On the last request the block pads: up to 16 pad words are
// written into the block RAM, then a compression follows, twice when the length
// no longer fits. Output channel: eight requests per message, word 0 first, each
// also carrying the XOR fold of the digest (a zero fold is sent as 1). A word is
// fetched from the chaining RAM into its read register, then loaded into the
// output register; a stall on out_stall_i holds the register and delays the next
// fetch. The input reopens once word 7 is loaded.
// Reset: asynchronous, active low; the chaining RAM reads as the initial hash
// values through per-entry valid flags, so no clearing pass is needed.

module sha256_message_hasher_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire sha_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output sha_pkg::out_t     out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH,
    ST_OUT
  } state_e;

  state_e       state_q;
  logic [6:0]   cnt_q;
  logic [5:0]   fill_q;
  logic [60:0]  count_q;
  logic [3:0]   widx_q;
  logic [2:0]   out_idx_q;
  logic         pad_q;
  logic         final_q;
  logic         marker_done_q;
  logic         rd_pend_q;
  logic         out_valid_q;
  logic [7:0]   chain_valid_q;
  logic         rd_valid_q;
  logic [2:0]   rd_addr_q;

  logic [31:0]  acc_q;
  logic [31:0]  wv_q [8];
  logic [31:0]  sch_q [16];
  logic [31:0]  fold_q;
  sha_pkg::out_t out_q;

  logic         in_fire;
  logic         out_fire;
  logic         out_issue;
  logic         out_load;
  logic [5:0]   fill_nx;

  logic         chain_re;
  logic [2:0]   chain_raddr;
  logic         chain_we;
  logic [31:0]  chain_wdata;
  logic [31:0]  chain_rdata;
  logic [31:0]  chain_rd;

  logic         buf_we;
  logic [3:0]   buf_waddr;
  logic [31:0]  buf_wdata;
  logic         buf_re;
  logic [31:0]  buf_rdata;

  logic         len_blk;
  logic [63:0]  bit_len;
  logic [31:0]  pad_word;
  logic [31:0]  marker_word;

  logic [5:0]   rnd_idx;
  logic [31:0]  w_cur;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  fold_fix;

  assign in_fire   = in_valid_i && (state_q == ST_IDLE);
  assign out_fire  = out_valid_q && !out_stall_i;
  // Fetch the next word only when the output register is empty next cycle.
  assign out_issue = (state_q == ST_OUT) && !rd_pend_q && (!out_valid_q || !out_stall_i);
  assign out_load  = (state_q == ST_OUT) && rd_pend_q;
  assign fill_nx   = in_data_i.has_byte ? fill_q + 6'd1 : fill_q;

  // Chaining words: entries never written since the last message read as the IV.
  assign chain_rd    = rd_valid_q ? chain_rdata : sha_pkg::INIT_H[rd_addr_q];
  assign chain_re    = (((state_q == ST_LOAD) || (state_q == ST_FINISH)) && (cnt_q < 7'd8))
                       || out_issue;
  assign chain_raddr = (state_q == ST_OUT) ? out_idx_q : cnt_q[2:0];
  // Write-back of entry j overlaps the read of entry j+1 only, so no forwarding.
  assign chain_we    = (state_q == ST_FINISH) && (cnt_q != 7'd0);
  assign chain_wdata = chain_rd + wv_q[0];

  sha_ram #(
    .WIDTH (32),
    .DEPTH (8)
  ) u_chain_ram (
    .clk_i     (clk_i),
    .wr_en_i   (chain_we),
    .wr_addr_i (rd_addr_q),
    .wr_data_i (chain_wdata),
    .rd_en_i   (chain_re),
    .rd_addr_i (chain_raddr),
    .rd_data_o (chain_rdata)
  );

  // Padding: marker word at the fill position, length in the last two words.
  assign len_blk = marker_done_q || (fill_q[5:3] != 3'd7);
  assign bit_len = {count_q, 3'b000};

  always_comb begin
    case (fill_q[1:0])
      2'd0:    marker_word = {sha_pkg::PAD_MARKER, 24'h0};
      2'd1:    marker_word = {acc_q[7:0], sha_pkg::PAD_MARKER, 16'h0};
      2'd2:    marker_word = {acc_q[15:0], sha_pkg::PAD_MARKER, 8'h0};
      default: marker_word = {acc_q[23:0], sha_pkg::PAD_MARKER};
    endcase
  end

  always_comb begin
    if (!marker_done_q && (widx_q == fill_q[5:2])) begin
      pad_word = marker_word;
    end else if (len_blk && (widx_q == 4'd14)) begin
      pad_word = bit_len[63:32];
    end else if (len_blk && (widx_q == 4'd15)) begin
      pad_word = bit_len[31:0];
    end else begin
      pad_word = 32'h0;
    end
  end

  assign buf_we    = (in_fire && in_data_i.has_byte && (fill_q[1:0] == 2'd3))
                     || (state_q == ST_PAD);
  assign buf_waddr = (state_q == ST_PAD) ? widx_q : fill_q[5:2];
  assign buf_wdata = (state_q == ST_PAD) ? pad_word : {acc_q[23:0], in_data_i.data_byte};
  assign buf_re    = (state_q == ST_ROUND) && (cnt_q < 7'd16);

  sha_ram #(
    .WIDTH (32),
    .DEPTH (16)
  ) u_block_ram (
    .clk_i     (clk_i),
    .wr_en_i   (buf_we),
    .wr_addr_i (buf_waddr),
    .wr_data_i (buf_wdata),
    .rd_en_i   (buf_re),
    .rd_addr_i (cnt_q[3:0]),
    .rd_data_o (buf_rdata)
  );

  // Round datapath: round cnt_q-1 runs while the block RAM word for it arrives.
  assign rnd_idx = 6'(cnt_q - 7'd1);
  assign w_cur   = (cnt_q <= 7'd16) ? buf_rdata
                 : sha_pkg::small_sigma1(sch_q[14]) + sch_q[9]
                   + sha_pkg::small_sigma0(sch_q[1]) + sch_q[0];
  assign t1      = wv_q[7] + sha_pkg::big_sigma1(wv_q[4])
                   + sha_pkg::choose(wv_q[4], wv_q[5], wv_q[6])
                   + sha_pkg::ROUND_K[rnd_idx] + w_cur;
  assign t2      = sha_pkg::big_sigma0(wv_q[0]) + sha_pkg::majority(wv_q[0], wv_q[1], wv_q[2]);
  assign fold_fix = (fold_q == 32'h0) ? 32'h1 : fold_q;

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      fill_q        <= '0;
      count_q       <= '0;
      widx_q        <= '0;
      out_idx_q     <= '0;
      pad_q         <= 1'b0;
      final_q       <= 1'b0;
      marker_done_q <= 1'b0;
      rd_pend_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      chain_valid_q <= '0;
      rd_valid_q    <= 1'b0;
    end else begin
      if (chain_re) begin
        rd_valid_q <= chain_valid_q[chain_raddr];
      end
      if (chain_we) begin
        chain_valid_q[rd_addr_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_data_i.has_byte) begin
              fill_q  <= fill_nx;
              count_q <= count_q + 61'd1;
            end
            if (in_data_i.has_byte && (fill_q == 6'd63)) begin
              // Full block: compress now, pad afterwards if this ends the message.
              state_q <= ST_LOAD;
              cnt_q   <= '0;
              pad_q   <= in_data_i.last_of_message;
            end else if (in_data_i.last_of_message) begin
              state_q <= ST_PAD;
              widx_q  <= fill_nx[5:2];
              pad_q   <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          widx_q <= widx_q + 4'd1;
          if (widx_q == 4'd15) begin
            state_q       <= ST_LOAD;
            cnt_q         <= '0;
            marker_done_q <= 1'b1;
            final_q       <= len_blk;
          end
        end
        ST_LOAD: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd8) begin
            state_q <= ST_ROUND;
            cnt_q   <= '0;
          end
        end
        ST_ROUND: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd64) begin
            state_q <= ST_FINISH;
            cnt_q   <= '0;
          end
        end
        ST_FINISH: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd8) begin
            cnt_q <= '0;
            if (final_q) begin
              state_q   <= ST_OUT;
              out_idx_q <= '0;
            end else if (pad_q) begin
              state_q <= ST_PAD;
              widx_q  <= '0;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          rd_pend_q <= out_issue;
          if (out_load) begin
            out_idx_q <= out_idx_q + 3'd1;
            if (out_idx_q == 3'd7) begin
              // Last word is in the output register: restart for the next message.
              state_q       <= ST_IDLE;
              chain_valid_q <= '0;
              fill_q        <= '0;
              count_q       <= '0;
              pad_q         <= 1'b0;
              final_q       <= 1'b0;
              marker_done_q <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (chain_re) begin
      rd_addr_q <= chain_raddr;
    end
    if (in_fire && in_data_i.has_byte) begin
      acc_q <= {acc_q[23:0], in_data_i.data_byte};
    end
    if (((state_q == ST_LOAD) || (state_q == ST_FINISH)) && (cnt_q != 7'd0)) begin
      for (int i = 0; i < 7; i++) begin
        wv_q[i] <= wv_q[i+1];
      end
      wv_q[7] <= chain_rd;
    end
    if ((state_q == ST_ROUND) && (cnt_q != 7'd0)) begin
      wv_q[0] <= t1 + t2;
      wv_q[1] <= wv_q[0];
      wv_q[2] <= wv_q[1];
      wv_q[3] <= wv_q[2];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[5] <= wv_q[4];
      wv_q[6] <= wv_q[5];
      wv_q[7] <= wv_q[6];
      for (int i = 0; i < 15; i++) begin
        sch_q[i] <= sch_q[i+1];
      end
      sch_q[15] <= w_cur;
    end
    if (state_q == ST_FINISH) begin
      if (cnt_q == 7'd0) begin
        fold_q <= '0;
      end else begin
        fold_q <= fold_q ^ chain_wdata;
      end
    end
    if (out_load) begin
      out_q.digest_word   <= chain_rd;
      out_q.word_number   <= out_idx_q;
      out_q.folded_digest <= fold_fix;
      out_q.last_word     <= (out_idx_q == 3'd7);
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_load_into_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("output register overwritten while full");

  a_idle_no_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !rd_pend_q)
    else $error("digest fetch pending while taking input");

  a_chain_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (chain_valid_q == 8'hff))
    else $error("digest read from unwritten chaining entry");

  a_last_word_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last_word) |-> (out_q.word_number == 3'd7))
    else $error("last word flag on wrong word");
`endif

endmodule

`default_nettype wire
